// ===== design/isqrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Integer square root package
// Shared widths, defaults and the controller-to-datapath command type.
// ----------------------------------------------------------------------------
package isqrt_pkg;

  localparam int unsigned RadicandW = 64;
  localparam int unsigned RootW = 32;
  localparam int unsigned DefaultRadicandWidth = 64;

  typedef struct packed {
    logic load;
    logic step;
  } isqrt_cmd_t;

endpackage

// ===== design/isqrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Integer square root controller
// Accepts an item, sequences one root bit per cycle and flags the result.
// ----------------------------------------------------------------------------
module isqrt_ctrl #(
  parameter int unsigned RADICAND_WIDTH = isqrt_pkg::DefaultRadicandWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  output logic                   valid_o,
  output isqrt_pkg::isqrt_cmd_t  cmd_o
);

  localparam int unsigned RootBits = (RADICAND_WIDTH + 1) / 2;
  localparam int unsigned CntW = $clog2(RootBits + 1);
  localparam logic [CntW-1:0] LastCnt = CntW'(RootBits - 1);

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic            valid_q;

  always_comb begin
    cmd_o.load = start && (state_q == StIdle);
    cmd_o.step = (state_q == StRun);
  end

  assign busy    = (state_q == StRun);
  assign valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (start) begin
            state_q <= StRun;
            cnt_q   <= LastCnt;
          end
        end
        StRun: begin
          if (cnt_q == '0) begin
            state_q <= StIdle;
            valid_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

// ===== design/isqrt_datapath.sv =====
// ----------------------------------------------------------------------------
// Integer square root datapath
// Restoring digit-by-digit square root, one root bit per step.
// ----------------------------------------------------------------------------
module isqrt_datapath #(
  parameter int unsigned RADICAND_WIDTH = isqrt_pkg::DefaultRadicandWidth
) (
  input  logic                              clk_i,
  input  isqrt_pkg::isqrt_cmd_t             cmd_i,
  input  logic [isqrt_pkg::RadicandW-1:0]   radicand_i,
  output logic [isqrt_pkg::RootW-1:0]       root_o
);

  localparam int unsigned RootBits = (RADICAND_WIDTH + 1) / 2;
  localparam int unsigned PadW = 2 * RootBits;
  localparam int unsigned RemW = RootBits + 1;
  localparam int unsigned TrialW = RootBits + 3;

  logic [PadW-1:0]     rad_q;
  logic [RemW-1:0]     rem_q;
  logic [RootBits-1:0] root_q;

  logic [TrialW-1:0] rem_shift;
  logic [TrialW-1:0] trial;
  logic [TrialW-1:0] diff;
  logic              keep;

  assign rem_shift = {rem_q, rad_q[PadW-1 -: 2]};
  assign trial     = TrialW'({root_q, 2'b01});
  assign keep      = (rem_shift >= trial);
  assign diff      = rem_shift - trial;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rad_q  <= PadW'(radicand_i[RADICAND_WIDTH-1:0]);
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.step) begin
      rad_q  <= rad_q << 2;
      rem_q  <= keep ? RemW'(diff) : RemW'(rem_shift);
      root_q <= RootBits'({root_q, keep});
    end
  end

  assign root_o = isqrt_pkg::RootW'(root_q);

endmodule

// ===== design/integer_square_root_unit.sv =====
// ----------------------------------------------------------------------------
// Integer square root unit
// Returns the floor square root of an unsigned radicand.
// ----------------------------------------------------------------------------
// An item is taken at a rising edge where start is high and busy is low;
// radicand_i is sampled at that edge. Radicand bits at and above
// RADICAND_WIDTH are ignored.
// The unit then decides one root bit per cycle, (RADICAND_WIDTH+1)/2 root
// bits in all, 32 at the default width. busy is high during that time.
// The root appears on root_o for one cycle with valid_o high, right after
// the last bit step. A new item may be started in that same cycle, but the
// unit does not take a new item before it is through with the last one; the
// bit-step loop runs through the single subtractor and comparator.
// The receiver cannot stall; it must take the result in its valid cycle.
// Reset returns the controller to idle and drops valid_o; a pending item is
// dropped.
// ----------------------------------------------------------------------------
module integer_square_root_unit #(
  parameter int unsigned RADICAND_WIDTH = isqrt_pkg::DefaultRadicandWidth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [isqrt_pkg::RadicandW-1:0] radicand_i,
  output logic                            valid_o,
  output logic [isqrt_pkg::RootW-1:0]     root_o
);

  isqrt_pkg::isqrt_cmd_t cmd;

  isqrt_ctrl #(
    .RADICAND_WIDTH(RADICAND_WIDTH)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .valid_o(valid_o),
    .cmd_o  (cmd)
  );

  isqrt_datapath #(
    .RADICAND_WIDTH(RADICAND_WIDTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .radicand_i(radicand_i),
    .root_o    (root_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("Accepted item did not make the unit busy.");

  a_valid_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($past(busy) && !busy))
    else $error("Result strobe without a finished computation.");

  a_valid_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("Result strobe lasted more than one cycle.");

  a_load_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.load && cmd.step))
    else $error("Datapath was told to load and step at once.");

endmodule

// ===== sim/integer_square_root_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Integer square root unit testbench
// Feeds radicands through the start/busy handshake with random gaps and
// checks every strobed root against a bit-serial floor square root computed
// in the bench. The items are directed corner values followed by random
// values: full-range, near perfect squares, scaled down and sparse.
// ----------------------------------------------------------------------------
module integer_square_root_unit_tb;

  localparam int unsigned RadicandBits = isqrt_pkg::DefaultRadicandWidth;
  localparam int unsigned RootBits = (RadicandBits + 1) / 2;
  localparam logic [isqrt_pkg::RadicandW-1:0] RadicandMask =
    {isqrt_pkg::RadicandW{1'b1}} >> (isqrt_pkg::RadicandW - RadicandBits);
  localparam int unsigned RandomItems = 1250;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned DrainCycles = RootBits + 8;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  logic [isqrt_pkg::RadicandW-1:0] radicand_i = '0;
  logic                            valid_o;
  logic [isqrt_pkg::RootW-1:0]     root_o;

  logic [isqrt_pkg::RadicandW-1:0] radicand_q[$];
  logic [isqrt_pkg::RootW-1:0]     root_expect_q[$];
  int unsigned                     gap_left = 0;
  int unsigned                     burst_left = 0;
  int unsigned                     idle_cycles = 0;
  int unsigned                     fail_count = 0;

  integer_square_root_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .radicand_i (radicand_i),
    .valid_o    (valid_o),
    .root_o     (root_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [isqrt_pkg::RootW-1:0] isqrt_floor(
    input logic [isqrt_pkg::RadicandW-1:0] value
  );
    logic [isqrt_pkg::RadicandW-1:0] masked;
    logic [isqrt_pkg::RadicandW-1:0] acc;
    logic [isqrt_pkg::RadicandW-1:0] trial;
    masked = value & RadicandMask;
    acc = '0;
    for (int b = RootBits - 1; b >= 0; b--) begin
      trial = acc | (64'd1 << b);
      if (trial * trial <= masked) begin
        acc = trial;
      end
    end
    return acc[isqrt_pkg::RootW-1:0];
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one, and bursts
  // with no gaps at all.
  function automatic int unsigned draw_gap();
    int unsigned pick;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (pick < 50) return 0;
    if (pick < 82) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 40);
    return $urandom_range(41, 200);
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        root_expect_q.push_back(isqrt_floor(radicand_i));
      end
      if (!start || !busy) begin
        if (gap_left == 0 && radicand_q.size() > 0) begin
          radicand_i <= radicand_q.pop_front();
          start <= 1'b1;
          gap_left <= draw_gap();
        end else begin
          start <= 1'b0;
          if (gap_left > 0) begin
            gap_left <= gap_left - 1;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    logic [isqrt_pkg::RootW-1:0] want;
    if (rst_ni && valid_o) begin
      if (root_expect_q.size() == 0) begin
        $error("root: expected none, actual %h", root_o);
        fail_count++;
      end else begin
        want = root_expect_q.pop_front();
        if (root_o !== want) begin
          $error("root: expected %h, actual %h", want, root_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || (valid_o && root_expect_q.size() > 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [isqrt_pkg::RadicandW-1:0] base;
    logic [isqrt_pkg::RadicandW-1:0] value;
    int unsigned                     kind;

    radicand_q = '{
      64'h0, 64'h1, 64'h2, 64'h3, 64'h4, 64'h18, 64'h19, 64'h1A,
      64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
      64'hFFFF_FFFE_0000_0001, 64'hFFFF_FFFE_0000_0000,
      64'hFFFF_FFFE_0000_0002, 64'h8000_0000_0000_0000,
      64'h7FFF_FFFF_FFFF_FFFF, 64'h4000_0000_0000_0000,
      64'h3FFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA,
      64'h5555_5555_5555_5555, 64'h0000_0001_0000_0000,
      64'h0000_0000_FFFF_FFFF
    };

    repeat (RandomItems) begin
      kind = $urandom_range(0, 99);
      value = {$urandom, $urandom};
      if (kind >= 35 && kind < 65) begin
        base = {32'h0, $urandom} >> $urandom_range(0, 31);
        value = base * base;
        case ($urandom_range(0, 3))
          0: value = value - 1;
          1: value = value + 1;
          2: value = value + ({32'h0, $urandom} % (2 * base + 1));
          default: ;
        endcase
      end else if (kind >= 65 && kind < 90) begin
        value = value >> $urandom_range(1, 63);
      end else if (kind >= 90) begin
        value = (64'd1 << $urandom_range(0, 63)) + $urandom_range(0, 2) - 1;
      end
      radicand_q.push_back(value);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    while ((radicand_q.size() > 0 || start || root_expect_q.size() > 0) &&
           idle_cycles < IdleLimit) begin
      @(negedge clk_i);
    end

    if (idle_cycles >= IdleLimit) begin
      $display("*** FAILED ***");
    end else begin
      repeat (DrainCycles) @(negedge clk_i);
      if (root_expect_q.size() > 0) begin
        $error("root: %0d results never arrived", root_expect_q.size());
        fail_count++;
      end
      if (fail_count == 0) begin
        $display("*** PASSED ***");
      end else begin
        $display("*** FAILED ***");
      end
    end
    $finish;
  end

endmodule
